@@ design/blpl_pkg.sv @@
// Shared types and constants for the bounded positional list.
// No dependencies; imported by every module of the block.
package blpl_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = 4;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W = 8;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_DUMP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic exec;
        logic dump_next;
    } blpl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic multi;
        logic idx_last;
    } blpl_stat_t;

endpackage

@@ design/blpl_ctrl.sv @@
// Controller for the bounded positional list: idle / dump sequencing.
// Depends on blpl_pkg.
module blpl_ctrl
    import blpl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  req_t       in_req,
    output logic       in_ready,
    input  blpl_stat_t stat,
    output blpl_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg;

    always_comb begin
        in_ready      = (state_reg == S_IDLE) && stat.out_free;
        cmd.exec      = in_valid && in_ready;
        cmd.dump_next = (state_reg == S_DUMP) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd.exec && in_req == REQ_DUMP && stat.multi) begin
                        state_reg <= S_DUMP;
                    end
                end
                S_DUMP: begin
                    if (cmd.dump_next && stat.idx_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/blpl_dpath.sv @@
// Datapath: shift-cell entry row, count, dump index and output register.
// Depends on blpl_pkg.
module blpl_dpath
    import blpl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  blpl_cmd_t           cmd,
    input  req_t                in_req,
    input  logic [POS_W-1:0]    in_pos,
    input  logic [DATA_W-1:0]   in_data,
    input  logic                out_ready,
    output blpl_stat_t          stat,
    output logic                out_valid,
    output status_t             out_status,
    output logic [DATA_W-1:0]   out_data,
    output logic [CNT_W-1:0]    out_count,
    output logic                out_last
);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              m_valid_reg;
    status_t           m_status_reg, st_next;
    logic [DATA_W-1:0] m_data_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic              m_last_reg;

    logic [POS_W-1:0]  pos_m1;
    logic [POS_W:0]    pos_ext, cnt_ext;
    logic              do_ins, do_del;

    assign pos_m1  = in_pos - POS_W'(1);
    assign pos_ext = {1'b0, in_pos};
    assign cnt_ext = (POS_W + 1)'(count_reg);

    assign stat.out_free = !m_valid_reg || out_ready;
    assign stat.multi    = count_reg > CNT_W'(1);
    assign stat.idx_last = CNT_W'(idx_reg) == count_reg - CNT_W'(1);

    always_comb begin
        st_next    = ST_OK;
        count_next = count_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        unique case (in_req)
            REQ_INSERT: begin
                if (in_pos == '0 || pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
                    st_next = ST_BADPOS;
                end else if (count_reg == CNT_W'(DEPTH)) begin
                    st_next = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (in_pos == '0 || pos_ext > cnt_ext) begin
                    st_next = ST_BADPOS;
                end else begin
                    do_del     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_CLEAR: count_next = '0;
            REQ_DUMP: begin
                if (count_reg == '0) begin
                    st_next = ST_EMPTY;
                end
            end
            default: st_next = ST_OK;
        endcase
    end

    // shift cells: each cell loads its neighbor, the new byte, or holds
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (cmd.exec && do_ins) begin
                if (POS_W'(i) == pos_m1) begin
                    entry_reg[i] <= in_data;
                end else if (i > 0 && POS_W'(i) > pos_m1) begin
                    entry_reg[i] <= entry_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.exec && do_del) begin
                if (i < DEPTH - 1 && POS_W'(i) >= pos_m1) begin
                    entry_reg[i] <= entry_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                count_reg   <= count_next;
                idx_reg     <= IDX_W'(1);
                m_valid_reg <= 1'b1;
            end else if (cmd.dump_next) begin
                idx_reg     <= idx_reg + IDX_W'(1);
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_status_reg <= st_next;
            m_count_reg  <= count_next;
            if (in_req == REQ_DUMP && count_reg != '0) begin
                m_data_reg <= entry_reg[0];
                m_last_reg <= count_reg == CNT_W'(1);
            end else begin
                m_data_reg <= '0;
                m_last_reg <= 1'b1;
            end
        end else if (cmd.dump_next) begin
            m_status_reg <= ST_OK;
            m_count_reg  <= count_reg;
            m_data_reg   <= entry_reg[idx_reg];
            m_last_reg   <= stat.idx_last;
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_data   = m_data_reg;
    assign out_count  = m_count_reg;
    assign out_last   = m_last_reg;

endmodule

@@ design/bounded_positional_list_top.sv @@
// Top level of the bounded positional list: stream ports, controller, datapath.
// Depends on blpl_pkg, blpl_ctrl and blpl_dpath.
//
// Ordered list of up to DEPTH (8) bytes in a row of shift cells. Insert,
// delete and clear take one word in and give one word out; a new word is
// taken as soon as the output register is free, so these sustain one word
// per cycle. A dump of N > 0 entries gives N words, one per cycle while the
// output register is free, read out by the dump index; no input is taken
// until the last has been loaded into the output register. Entry cells hold
// no reset value; reset clears the count, dump index and output valid flag.
module bounded_positional_list_top
    import blpl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[7:0], data_in[15:8]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_out[7:0], entry_count[11:8], zero[15:12]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    blpl_cmd_t         cmd;
    blpl_stat_t        stat;
    req_t              req;
    status_t           out_status;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  out_count;

    assign req = req_t'(s_tuser);

    blpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (req),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    blpl_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_req     (req),
        .in_pos     (s_tdata[7:0]),
        .in_data    (s_tdata[15:8]),
        .out_ready  (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0, out_count, out_data};
    assign m_tuser = out_status;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= CNT_W'(DEPTH))
        else $error("entry_count above list depth");

    a_dump_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during a dump");

    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    a_dump_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == ST_OK && m_tdata[11:8] > CNT_W'(1))
        else $error("dump word with bad status or count");

endmodule

@@ tb/tb_bounded_positional_list_top.sv @@
// Self-checking testbench for bounded_positional_list_top: a directed table, then random
// insert/delete/clear/dump words, with results checked against an in-bench list model.
// Depends on blpl_pkg and the design files under design/.
module tb_bounded_positional_list_top import blpl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_WORDS = 205;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic [3:0] cnt;
        logic       last;
    } list_word_t;

    typedef struct packed {
        req_t       rq;
        logic [7:0] pos;
        logic [7:0] din;
        logic       typed;
        status_t    st;
        logic [3:0] cnt;
    } stim_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [7:0]  list_mem [DEPTH];
    int unsigned list_len = 0;
    list_word_t  list_expect [$];
    list_word_t  want;

    int errors = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;

    // typed rows carry their expected single result word
    stim_row_t stim_rows [25] = '{
        '{REQ_DUMP,   8'd0,   8'h00, 1'b1, ST_EMPTY,  4'd0},
        '{REQ_DELETE, 8'd1,   8'h00, 1'b1, ST_BADPOS, 4'd0},
        '{REQ_INSERT, 8'd0,   8'h12, 1'b1, ST_BADPOS, 4'd0},
        '{REQ_INSERT, 8'd2,   8'h34, 1'b1, ST_BADPOS, 4'd0},
        '{REQ_INSERT, 8'd1,   8'h00, 1'b1, ST_OK,     4'd1},
        '{REQ_INSERT, 8'd2,   8'hFF, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd1,   8'hA5, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd2,   8'h5A, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd5,   8'h11, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd3,   8'h22, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd7,   8'h33, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd8,   8'h44, 1'b0, ST_OK,     4'd0},
        '{REQ_INSERT, 8'd9,   8'h55, 1'b1, ST_FULL,   4'd8},
        '{REQ_INSERT, 8'd10,  8'h66, 1'b1, ST_BADPOS, 4'd8},
        '{REQ_INSERT, 8'd255, 8'hFF, 1'b1, ST_BADPOS, 4'd8},
        '{REQ_DUMP,   8'd0,   8'h00, 1'b0, ST_OK,     4'd0},
        '{REQ_DELETE, 8'd0,   8'h00, 1'b1, ST_BADPOS, 4'd8},
        '{REQ_DELETE, 8'd9,   8'h00, 1'b1, ST_BADPOS, 4'd8},
        '{REQ_DELETE, 8'd8,   8'h00, 1'b0, ST_OK,     4'd0},
        '{REQ_DELETE, 8'd1,   8'h00, 1'b0, ST_OK,     4'd0},
        '{REQ_DELETE, 8'd3,   8'h00, 1'b0, ST_OK,     4'd0},
        '{REQ_DUMP,   8'd255, 8'hFF, 1'b0, ST_OK,     4'd0},
        '{REQ_CLEAR,  8'd0,   8'h00, 1'b1, ST_OK,     4'd0},
        '{REQ_CLEAR,  8'd255, 8'hFF, 1'b1, ST_OK,     4'd0},
        '{REQ_DUMP,   8'd0,   8'h00, 1'b1, ST_EMPTY,  4'd0}
    };

    bounded_positional_list_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Updates the list copy for one accepted word and, unless quiet, queues its result words.
    task automatic predict_list(input req_t rq, input logic [7:0] pos, input logic [7:0] din,
                                input bit quiet);
        status_t    st;
        list_word_t w;
        int         i;
        st = ST_OK;
        case (rq)
            REQ_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    st = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    st = ST_FULL;
                end else begin
                    for (i = list_len; i >= int'(pos); i--) list_mem[i] = list_mem[i - 1];
                    list_mem[pos - 1] = din;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    st = ST_BADPOS;
                end else begin
                    for (i = pos - 1; i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            REQ_CLEAR: begin
                list_len = 0;
            end
            default: begin
                if (list_len == 0) st = ST_EMPTY;
            end
        endcase
        if (quiet) return;
        if (rq == REQ_DUMP && list_len != 0) begin
            for (i = 0; i < int'(list_len); i++) begin
                w = '{status: ST_OK, data: list_mem[i], cnt: 4'(list_len),
                      last: (i + 1 == int'(list_len))};
                list_expect.push_back(w);
            end
        end else begin
            w = '{status: st, data: 8'h00, cnt: 4'(list_len), last: 1'b1};
            list_expect.push_back(w);
        end
    endtask

    task automatic send_word(input req_t rq, input logic [7:0] pos, input logic [7:0] din,
                             input bit quiet);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {din, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_list(rq, pos, din, quiet);
    endtask

    task automatic random_word();
        req_t       rq;
        logic [7:0] pos;
        int         r;
        r = $urandom_range(99);
        if (r < 48)      rq = REQ_INSERT;
        else if (r < 78) rq = REQ_DELETE;
        else if (r < 93) rq = REQ_DUMP;
        else             rq = REQ_CLEAR;
        r = $urandom_range(99);
        if (r < 8)                 pos = 8'd0;
        else if (r < 18)           pos = 8'($urandom_range(255));
        else if (rq == REQ_INSERT) pos = 8'($urandom_range(list_len + 1, 1));
        else                       pos = 8'($urandom_range((list_len == 0) ? 1 : list_len, 1));
        send_word(rq, pos, 8'($urandom_range(255)), 1'b0);
    endtask

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (list_expect.size() == 0) begin
                $error("unexpected word: tdata=%h tuser=%h tlast=%b", m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = list_expect.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== want.data) begin
                    $error("data_out: expected %h, got %h", want.data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[11:8] !== want.cnt) begin
                    $error("entry_count: expected %0d, got %0d", want.cnt, m_tdata[11:8]);
                    errors++;
                end
                if (m_tdata[15:12] !== 4'd0) begin
                    $error("pad: expected 0, got %h", m_tdata[15:12]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** bounded_positional_list_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 33;
        rx_idle_pct = 55;
        foreach (stim_rows[k]) begin
            send_word(stim_rows[k].rq, stim_rows[k].pos, stim_rows[k].din, stim_rows[k].typed);
            if (stim_rows[k].typed)
                list_expect.push_back('{status: stim_rows[k].st, data: 8'h00,
                                        cnt: stim_rows[k].cnt, last: 1'b1});
        end
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == RAND_WORDS / 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 33;
            end
            if (n == 2 * RAND_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_left = HOLD_CYCLES;
            end
            random_word();
        end
        s_tvalid <= 1'b0;
        while (list_expect.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && list_expect.size() == 0) begin
            $display("** bounded_positional_list_top: PASSED **");
        end else begin
            $display("** bounded_positional_list_top: FAILED **");
        end
        $finish;
    end

endmodule
